// ----- hw/rtl/dmpc_pkg.sv -----
// Shared types and constants for the dot-matrix pixel capture block.
// Used by dmpc_cfg_regs and dot_matrix_pixel_capture; depends on nothing.
package dmpc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_BIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_SYNC_BIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_BIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIT_LEVEL    = 3'd3;

    localparam logic [2:0] RST_CLOCK_BIT    = 3'd0;
    localparam logic [2:0] RST_ROW_SYNC_BIT = 3'd1;
    localparam logic [2:0] RST_DATA_BIT     = 3'd2;
    localparam logic [7:0] RST_LIT_LEVEL    = 8'd42;

    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    typedef struct packed {
        logic [2:0] clock_bit;
        logic [2:0] row_sync_bit;
        logic [2:0] data_bit;
        logic [7:0] lit_level;
    } t_cfg;

endpackage

// ----- hw/rtl/dmpc_cfg_regs.sv -----
// Configuration register file of the pixel capture block.
// Depends on dmpc_pkg for the register indexes, reset values and t_cfg.
module dmpc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [dmpc_pkg::CFG_INDEX_W-1:0]   i_index,
    input  logic [dmpc_pkg::CFG_DATA_W-1:0]    i_data,
    output dmpc_pkg::t_cfg                     o_cfg
);

    dmpc_pkg::t_cfg r_cfg;
    dmpc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_index)
                dmpc_pkg::REG_CLOCK_BIT:    n_cfg.clock_bit    = i_data[2:0];
                dmpc_pkg::REG_ROW_SYNC_BIT: n_cfg.row_sync_bit = i_data[2:0];
                dmpc_pkg::REG_DATA_BIT:     n_cfg.data_bit     = i_data[2:0];
                dmpc_pkg::REG_LIT_LEVEL:    n_cfg.lit_level    = i_data[7:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_bit    <= dmpc_pkg::RST_CLOCK_BIT;
            r_cfg.row_sync_bit <= dmpc_pkg::RST_ROW_SYNC_BIT;
            r_cfg.data_bit     <= dmpc_pkg::RST_DATA_BIT;
            r_cfg.lit_level    <= dmpc_pkg::RST_LIT_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/dot_matrix_pixel_capture.sv -----
// An accepted sample request has its result in the output register in the next cycle.
// Throughput: one sample per cycle while the input is not stalled; edge detection and counter update are combinational.
// The output register is refilled in the cycle it is taken, so input only stalls while
// a result waits under output stall. Synchronous active-low reset clears the counters,
// the previous levels, the output valid and sets the configuration registers to defaults.
module dot_matrix_pixel_capture #(
    parameter int NUM_COLUMNS = 128,
    parameter int NUM_ROWS    = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_sample,
    input  logic                               i_frame_start,
    input  logic                               i_frame_end,
    input  logic                               i_frame_locked,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_pixel_write,
    output logic [dmpc_pkg::ROW_OUT_W-1:0]     o_pixel_row,
    output logic [dmpc_pkg::COL_OUT_W-1:0]     o_pixel_column,
    output logic [7:0]                         o_pixel_level,
    output logic                               o_frame_done,
    output logic                               o_frame_was_locked,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dmpc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [dmpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int COL_W = $clog2(NUM_COLUMNS + 1);
    localparam int ROW_W = $clog2(NUM_ROWS + 1);
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(NUM_COLUMNS);
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(NUM_ROWS);

    dmpc_pkg::t_cfg cfg;

    logic             r_prev_clk;
    logic             r_prev_sync;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             n_prev_clk;
    logic             n_prev_sync;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic                           r_out_valid;
    logic                           r_write;
    logic [dmpc_pkg::ROW_OUT_W-1:0] r_row_out;
    logic [dmpc_pkg::COL_OUT_W-1:0] r_col_out;
    logic [7:0]                     r_level;
    logic                           r_done;
    logic                           r_was_locked;

    logic                           n_write;
    logic [dmpc_pkg::ROW_OUT_W-1:0] n_row_out;
    logic [dmpc_pkg::COL_OUT_W-1:0] n_col_out;
    logic [7:0]                     n_level;

    logic in_accept;
    logic clk_bit;
    logic sync_bit;
    logic dat_bit;
    logic capture;
    logic [ROW_W+dmpc_pkg::ROW_OUT_W-1:0] row_ext;
    logic [COL_W+dmpc_pkg::COL_OUT_W-1:0] col_ext;

    dmpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;

    assign clk_bit  = i_sample[cfg.clock_bit];
    assign sync_bit = i_sample[cfg.row_sync_bit];
    assign dat_bit  = i_sample[cfg.data_bit];

    assign capture = ~i_frame_start & clk_bit & ~r_prev_clk
                   & (r_col < COL_LIMIT) & (r_row < ROW_LIMIT);

    // Counters are wider or narrower than the fixed output fields depending on the
    // frame geometry, so widen first and keep the low bits.
    assign row_ext = {{dmpc_pkg::ROW_OUT_W{1'b0}}, r_row};
    assign col_ext = {{dmpc_pkg::COL_OUT_W{1'b0}}, r_col};

    always_comb begin
        n_prev_clk  = clk_bit;
        n_prev_sync = sync_bit;
        n_col       = r_col;
        n_row       = r_row;
        if (i_frame_start) begin
            n_col = '0;
            n_row = '0;
        end else begin
            if (capture) begin
                n_col = r_col + 1'b1;
            end
            // A row sync edge on the same sample wins over the column step.
            if (sync_bit && !r_prev_sync) begin
                n_col = '0;
                if (r_row < ROW_LIMIT) begin
                    n_row = r_row + 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_write   = capture & i_frame_locked;
        n_row_out = '0;
        n_col_out = '0;
        n_level   = '0;
        if (n_write) begin
            n_row_out = row_ext[dmpc_pkg::ROW_OUT_W-1:0];
            n_col_out = col_ext[dmpc_pkg::COL_OUT_W-1:0];
            n_level   = dat_bit ? cfg.lit_level : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clk  <= 1'b0;
            r_prev_sync <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_prev_clk  <= n_prev_clk;
                r_prev_sync <= n_prev_sync;
                r_col       <= n_col;
                r_row       <= n_row;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_write      <= n_write;
            r_row_out    <= n_row_out;
            r_col_out    <= n_col_out;
            r_level      <= n_level;
            r_done       <= i_frame_end;
            r_was_locked <= i_frame_end & i_frame_locked;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_pixel_write      = r_write;
    assign o_pixel_row        = r_row_out;
    assign o_pixel_column     = r_col_out;
    assign o_pixel_level      = r_level;
    assign o_frame_done       = r_done;
    assign o_frame_was_locked = r_was_locked;

`ifndef ASSERT_OFF
    a_counters_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_LIMIT) && (r_row <= ROW_LIMIT))
        else $error("pixel counters left their range");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_frame_start) |=> (r_col == '0) && (r_row == '0) && !r_write)
        else $error("frame start did not clear the counters");

    a_past_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_frame_start && (r_row == ROW_LIMIT)) |=> !r_write)
        else $error("pixel written beyond the last row");

    a_locked_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_was_locked) |-> r_done)
        else $error("lock status reported outside a frame end");

    a_unlocked_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_frame_locked) |=> !r_write && (r_level == 8'd0))
        else $error("pixel written in an unlocked frame");
`endif

endmodule
